// ----- rtl/twmv_pkg.sv -----
// Shared types and constants for the time window mean/variance block.
// No dependencies; used by twmv_cfg and time_window_mean_variance_top in rtl.
package twmv_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int TIME_BITS_DEF  = 32;
  localparam int VALUE_BITS_DEF = 24;

  localparam int SPAN_BITS = 32;
  localparam int VAR_BITS  = 48;
  localparam int CNT_BITS  = 8;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [SPAN_BITS-1:0] SPAN_RESET   = SPAN_BITS'(1000000);
  localparam logic [VAR_BITS-1:0]  MINVAR_RESET = VAR_BITS'(1);

  // register index, taken from paddr[3]
  localparam logic REG_WINDOW_SPAN  = 1'b0;
  localparam logic REG_MIN_VARIANCE = 1'b1;

  typedef struct packed {
    logic [SPAN_BITS-1:0] window_span;
    logic [VAR_BITS-1:0]  min_variance;
  } cfg_t;

endpackage

// ----- rtl/twmv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module twmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/twmv_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// No dependencies.
module twmv_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   nreg;
  logic [DW-1:0]   dreg;
  logic [DW-1:0]   rem;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  always_comb begin
    rem_sh  = {rem, nreg[NW-1]};
    ge      = rem_sh >= {1'b0, dreg};
    rem_sub = rem_sh - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
        nreg <= num;
        dreg <= den;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        rem  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo  <= {quo[NW-2:0], ge};
        nreg <= {nreg[NW-2:0], 1'b0};
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/twmv_cfg.sv -----
// APB-style register file for window span and variance floor.
// Depends on twmv_pkg.
module twmv_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [twmv_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [twmv_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [twmv_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output twmv_pkg::cfg_t                      cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_span  <= twmv_pkg::SPAN_RESET;
      cfg.min_variance <= twmv_pkg::MINVAR_RESET;
    end else if (wr) begin
      unique case (paddr[3])
        twmv_pkg::REG_WINDOW_SPAN:
          cfg.window_span <= pwdata[twmv_pkg::SPAN_BITS-1:0];
        twmv_pkg::REG_MIN_VARIANCE:
          cfg.min_variance <= pwdata[twmv_pkg::VAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      twmv_pkg::REG_WINDOW_SPAN:
        prdata = twmv_pkg::CFG_DATA_BITS'(cfg.window_span);
      twmv_pkg::REG_MIN_VARIANCE:
        prdata = twmv_pkg::CFG_DATA_BITS'(cfg.min_variance);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/time_window_mean_variance_top.sv -----
// Sliding time window, time-weighted mean and variance of timestamped samples.
// Depends on twmv_pkg, twmv_ram, twmv_div and twmv_cfg.
//
// Usage:
//   Input beats (sample_time, sample_value) enter on in_valid/in_stall; one
//   result beat per input leaves on out_valid/out_stall. Registers window_span
//   (byte 0) and min_variance (byte 8) sit on the APB port; write them only
//   while the block is idle.
//   One sample is worked on at a time: in_stall is high from the accept until
//   the result has been loaded into the output register. Samples live in one
//   RAM of (time, value) pairs, read one entry per access through its
//   registered read port, so the work follows the walk over that RAM:
//     states S_EV_RD, S_EV_CHK per entry checked for eviction (evicted ones
//     plus one), S_P_RD, S_P_DAT, S_P1_ACC per segment for the mean sum,
//     S_P_RD, S_P_DAT, S_P2_LO, S_P2_HI, S_P2_ACC per segment for the variance
//     sum, and the two divisions in the shared one-bit-per-cycle divider;
//     both sums and divisions are skipped when the window covers zero time.
//   A finished result waits in the output register while out_stall is high;
//   the next sample is taken meanwhile and only its result waits for the slot.
//   Reset empties the ring, clears out_valid and restores the registers; the
//   RAM contents are left as they are and are never read before written.
module time_window_mean_variance_top #(
  parameter int DEPTH      = twmv_pkg::DEPTH_DEF,
  parameter int TIME_BITS  = twmv_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = twmv_pkg::VALUE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // sample channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [TIME_BITS-1:0]                      sample_time,
  input  logic signed [VALUE_BITS-1:0]              sample_value,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [VALUE_BITS-1:0]              window_mean,
  output logic [twmv_pkg::VAR_BITS-1:0]             window_variance,
  output logic [twmv_pkg::CNT_BITS-1:0]             points_held,
  output logic                                      zero_span,
  output logic                                      dropped_full,
  // configuration
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [twmv_pkg::CFG_ADDR_BITS-1:0]        paddr,
  input  logic [twmv_pkg::CFG_DATA_BITS-1:0]        pwdata,
  output logic [twmv_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                      pready
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int MW   = TIME_BITS + VALUE_BITS;
  localparam int ABW  = VALUE_BITS + 1;          // sum of two offset values
  localparam int P1W  = ABW + TIME_BITS;         // mean sum
  localparam int SQW  = 2 * ABW;                 // squared deviation
  localparam int HLO  = (SQW + 1) / 2;
  localparam int HHI  = SQW - HLO;
  localparam int ACCW = SQW + TIME_BITS;         // variance sum
  localparam int NW   = ACCW + 1;                // divider numerator
  localparam int DW   = TIME_BITS + 2;           // divider denominator
  localparam int VB   = twmv_pkg::VAR_BITS;
  localparam int QW   = (NW > VB + 1) ? NW : VB + 1;
  localparam int GW   = (TIME_BITS > twmv_pkg::SPAN_BITS) ? TIME_BITS
                                                          : twmv_pkg::SPAN_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EV_RD   = 4'd1;
  localparam logic [3:0] S_EV_CHK  = 4'd2;
  localparam logic [3:0] S_P_RD    = 4'd3;
  localparam logic [3:0] S_P_DAT   = 4'd4;
  localparam logic [3:0] S_P1_ACC  = 4'd5;
  localparam logic [3:0] S_D1_GO   = 4'd6;
  localparam logic [3:0] S_D1_WAIT = 4'd7;
  localparam logic [3:0] S_P2_LO   = 4'd8;
  localparam logic [3:0] S_P2_HI   = 4'd9;
  localparam logic [3:0] S_P2_ACC  = 4'd10;
  localparam logic [3:0] S_D2_GO   = 4'd11;
  localparam logic [3:0] S_D2_WAIT = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  twmv_pkg::cfg_t cfg;

  // control
  logic [3:0]           state;
  logic [AW-1:0]        oldest;
  logic [AW-1:0]        newest;
  logic [CW-1:0]        count;
  logic                 pass2;
  logic [AW-1:0]        k;
  logic [CW-1:0]        segs;

  // working data
  logic [TIME_BITS-1:0]  newest_time;
  logic [TIME_BITS-1:0]  t_cur;
  logic [VALUE_BITS-1:0] v_cur;
  logic [TIME_BITS-1:0]  span;
  logic [TIME_BITS-1:0]  first_t;
  logic [VALUE_BITS-1:0] first_v;
  logic [TIME_BITS-1:0]  prev_t;
  logic [VALUE_BITS-1:0] prev_v;
  logic [TIME_BITS-1:0]  dt_reg;
  logic [P1W-1:0]        prod1;
  logic [P1W-1:0]        s;
  logic [SQW-1:0]        sq;
  logic [HLO+TIME_BITS-1:0] plo;
  logic [HHI+TIME_BITS-1:0] phi;
  logic [ACCW-1:0]       acc;
  logic [VALUE_BITS-1:0] mu;
  logic                  dropped;
  logic                  res_zero;
  logic [VALUE_BITS-1:0] res_mean;
  logic [VB-1:0]         res_var;

  // accept-cycle ring update
  logic                  accept;
  logic [TIME_BITS-1:0]  t_eff;
  logic [AW-1:0]         oldest_new;
  logic [AW-1:0]         newest_new;
  logic [CW-1:0]         count_new;
  logic                  drop_new;

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [MW-1:0]         ram_rdata;
  logic [TIME_BITS-1:0]  rd_t;
  logic [VALUE_BITS-1:0] rd_v;

  // segment datapath
  logic [TIME_BITS-1:0]  age;
  logic [ABW-1:0]        ab;
  logic [ABW-1:0]        m2;
  logic [ABW-1:0]        ad;
  logic [TIME_BITS-1:0]  dt;

  // divider
  logic                  div_start;
  logic [NW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  logic                  div_done;
  logic [NW-1:0]         div_quo;
  logic [QW-1:0]         quo_ext;
  logic [VB-1:0]         var_sat;
  logic [CW+7:0]         count_ext;
  logic                  out_free;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  twmv_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Append: clamp time to the newest stored, drop the oldest when full.
  always_comb begin
    t_eff      = sample_time;
    oldest_new = oldest;
    newest_new = newest;
    count_new  = count;
    drop_new   = 1'b0;
    if (count == '0) begin
      oldest_new = '0;
      newest_new = '0;
      count_new  = CW'(1);
    end else begin
      if (sample_time < newest_time) begin
        t_eff = newest_time;
      end
      if (count == CW'(DEPTH)) begin
        oldest_new = next_idx(oldest);
        drop_new   = 1'b1;
      end else begin
        count_new = count + CW'(1);
      end
      newest_new = next_idx(newest);
    end
  end

  assign ram_we    = accept;
  assign ram_raddr = (state == S_P_RD) ? k : oldest;

  twmv_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_new),
    .wdata ({t_eff, sample_value}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_t = ram_rdata[MW-1:VALUE_BITS];
  assign rd_v = ram_rdata[VALUE_BITS-1:0];

  always_comb begin
    age = t_cur - rd_t;
    dt  = rd_t - prev_t;
    // offset-binary values make the sums unsigned
    ab  = {1'b0, ~prev_v[VALUE_BITS-1], prev_v[VALUE_BITS-2:0]}
        + {1'b0, ~rd_v[VALUE_BITS-1], rd_v[VALUE_BITS-2:0]};
    m2  = {mu, 1'b0};
    ad  = (ab >= m2) ? ab - m2 : m2 - ab;
  end

  always_comb begin
    div_start = (state == S_D1_GO) || (state == S_D2_GO);
    if (state == S_D1_GO) begin
      div_num = NW'(s) + NW'(span);
      div_den = DW'({span, 1'b0});
    end else begin
      div_num = NW'(acc) + NW'({span, 1'b0});
      div_den = {span, 2'b00};
    end
  end

  twmv_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    quo_ext = QW'(div_quo);
    var_sat = (quo_ext[QW-1:VB] != '0) ? '1 : quo_ext[VB-1:0];
    if (var_sat < cfg.min_variance) begin
      var_sat = cfg.min_variance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      newest    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken beat; a result loaded in S_FIN sets it again
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            oldest      <= oldest_new;
            newest      <= newest_new;
            count       <= count_new;
            dropped     <= drop_new;
            newest_time <= t_eff;
            t_cur       <= t_eff;
            v_cur       <= sample_value;
            state       <= S_EV_RD;
          end
        end
        S_EV_RD: begin
          state <= S_EV_CHK;
        end
        S_EV_CHK: begin
          if (count > CW'(1) && GW'(age) > GW'(cfg.window_span)) begin
            // evict and look at the next oldest
            oldest <= next_idx(oldest);
            count  <= count - CW'(1);
            state  <= S_EV_RD;
          end else begin
            span    <= age;
            first_t <= rd_t;
            first_v <= rd_v;
            prev_t  <= rd_t;
            prev_v  <= rd_v;
            k       <= next_idx(oldest);
            segs    <= count - CW'(1);
            s       <= '0;
            pass2   <= 1'b0;
            if (age == '0) begin
              res_zero <= 1'b1;
              res_mean <= v_cur;
              res_var  <= cfg.min_variance;
              state    <= S_FIN;
            end else begin
              res_zero <= 1'b0;
              state    <= S_P_RD;
            end
          end
        end
        S_P_RD: begin
          state <= S_P_DAT;
        end
        S_P_DAT: begin
          prev_t <= rd_t;
          prev_v <= rd_v;
          dt_reg <= dt;
          k      <= next_idx(k);
          segs   <= segs - CW'(1);
          if (pass2) begin
            sq    <= ad * ad;
            state <= S_P2_LO;
          end else begin
            prod1 <= ab * dt;
            state <= S_P1_ACC;
          end
        end
        S_P1_ACC: begin
          s     <= s + prod1;
          state <= (segs == '0) ? S_D1_GO : S_P_RD;
        end
        S_D1_GO: begin
          state <= S_D1_WAIT;
        end
        S_D1_WAIT: begin
          if (div_done) begin
            // mean stays in offset form for the second pass
            mu       <= (div_quo[NW-1:VALUE_BITS] != '0) ? '1
                                                         : div_quo[VALUE_BITS-1:0];
            res_mean <= (div_quo[NW-1:VALUE_BITS] != '0)
                        ? {1'b0, {(VALUE_BITS-1){1'b1}}}
                        : {~div_quo[VALUE_BITS-1], div_quo[VALUE_BITS-2:0]};
            prev_t   <= first_t;
            prev_v   <= first_v;
            k        <= next_idx(oldest);
            segs     <= count - CW'(1);
            acc      <= '0;
            pass2    <= 1'b1;
            state    <= S_P_RD;
          end
        end
        S_P2_LO: begin
          plo   <= sq[HLO-1:0] * dt_reg;
          state <= S_P2_HI;
        end
        S_P2_HI: begin
          acc   <= acc + ACCW'(plo);
          phi   <= sq[SQW-1:HLO] * dt_reg;
          state <= S_P2_ACC;
        end
        S_P2_ACC: begin
          acc   <= acc + (ACCW'(phi) << HLO);
          state <= (segs == '0) ? S_D2_GO : S_P_RD;
        end
        S_D2_GO: begin
          state <= S_D2_WAIT;
        end
        S_D2_WAIT: begin
          if (div_done) begin
            res_var <= var_sat;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid       <= 1'b1;
            window_mean     <= res_mean;
            window_variance <= res_var;
            points_held     <= count_ext[7:0];
            zero_span       <= res_zero;
            dropped_full    <= dropped;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = {8'd0, count};

endmodule

// ----- rtl/twmv_check.sv -----
// Port-level checker for the time window mean/variance block, with its bind.
// Depends on time_window_mean_variance_top.
module twmv_check #(
  parameter int CNT_W = 8
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] points_held
);

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // one sample at a time: an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  // the newest sample always stays in the window
  a_points_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> points_held != '0)
    else $error("result with empty window");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(points_held))
    else $error("stalled result beat changed");

endmodule

bind time_window_mean_variance_top twmv_check u_twmv_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .points_held (points_held)
);

// ----- test/tb_time_window_mean_variance_top.sv -----
// Self-checking testbench for time_window_mean_variance_top: random timestamped
// samples against an in-bench model of the sliding-window mean and variance.
// Depends on rtl/twmv_pkg.sv and the block's RTL.
module tb_time_window_mean_variance_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 128;
  localparam logic [23:0] VBIAS = 24'h800000;
  localparam logic [47:0] VAR_TOP = 48'hFFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam logic [3:0] ADDR_SPAN = 4'(8 * twmv_pkg::REG_WINDOW_SPAN);
  localparam logic [3:0] ADDR_MINVAR = 4'(8 * twmv_pkg::REG_MIN_VARIANCE);

  typedef struct {
    logic [23:0] mean;
    logic [47:0] variance;
    logic [7:0]  held;
    logic        zero;
    logic        dropped;
  } window_stats_t;

  // Window model and pending-result store.
  class window_board;
    logic [31:0] span_reg;
    logic [47:0] floor_reg;
    logic [31:0] ts[RING];
    logic [23:0] vs[RING];
    int oldest, newest, count;
    window_stats_t pending[$];
    int mismatches;
    int checked;
    int zero_seen, drop_seen;

    function new();
      span_reg = twmv_pkg::SPAN_RESET;
      floor_reg = twmv_pkg::MINVAR_RESET;
      oldest = 0;
      newest = 0;
      count = 0;
      mismatches = 0;
      checked = 0;
      zero_seen = 0;
      drop_seen = 0;
    endfunction

    function void note_sample(logic [31:0] t_in, logic [23:0] v);
      logic [31:0] t, span, dt;
      logic [127:0] s, acc, q;
      logic [24:0] ab, m2, ad;
      logic [23:0] mu;
      window_stats_t e;
      int k, n, i;
      t = t_in;
      e.dropped = 1'b0;
      e.zero = 1'b0;
      if (count == 0) begin
        oldest = 0;
        newest = 0;
        count = 1;
      end else begin
        // stored times never go backward
        if (t < ts[newest]) t = ts[newest];
        if (count >= RING) begin
          oldest = (oldest + 1) % RING;
          count--;
          e.dropped = 1'b1;
        end
        newest = (newest + 1) % RING;
        count++;
      end
      ts[newest] = t;
      vs[newest] = v;
      while (count > 1 && (t - ts[oldest]) > span_reg) begin
        oldest = (oldest + 1) % RING;
        count--;
      end
      span = t - ts[oldest];
      if (span == 0) begin
        e.zero = 1'b1;
        e.mean = v;
        e.variance = floor_reg;
      end else begin
        s = '0;
        k = oldest;
        for (i = 0; i + 1 < count; i++) begin
          n = (k + 1) % RING;
          ab = {1'b0, vs[k] ^ VBIAS} + {1'b0, vs[n] ^ VBIAS};
          dt = ts[n] - ts[k];
          s = s + 128'(ab) * 128'(dt);
          k = n;
        end
        q = (s + 128'(span)) / (128'(span) * 2);
        mu = (q > 128'(24'hFFFFFF)) ? 24'hFFFFFF : q[23:0];
        e.mean = mu ^ VBIAS;
        m2 = {mu, 1'b0};
        acc = '0;
        k = oldest;
        for (i = 0; i + 1 < count; i++) begin
          n = (k + 1) % RING;
          ab = {1'b0, vs[k] ^ VBIAS} + {1'b0, vs[n] ^ VBIAS};
          ad = (ab >= m2) ? ab - m2 : m2 - ab;
          dt = ts[n] - ts[k];
          acc = acc + 128'(ad) * 128'(ad) * 128'(dt);
          k = n;
        end
        q = (acc + 128'(span) * 2) / (128'(span) * 4);
        e.variance = (q > 128'(VAR_TOP)) ? VAR_TOP : q[47:0];
        if (e.variance < floor_reg) e.variance = floor_reg;
      end
      e.held = count[7:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [23:0] mean, logic [47:0] variance, logic [7:0] held,
                               logic zero, logic dropped);
      window_stats_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: mean %h var %h", mean, variance);
        return;
      end
      e = pending.pop_front();
      checked++;
      zero_seen += zero;
      drop_seen += dropped;
      if (mean !== e.mean || variance !== e.variance || held !== e.held ||
          zero !== e.zero || dropped !== e.dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp mean %h var %h held %0d zero %b drop %b | got %h %h %0d %b %b",
                   checked, e.mean, e.variance, e.held, e.zero, e.dropped,
                   mean, variance, held, zero, dropped);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall;
  logic [31:0] sample_time;
  logic signed [23:0] sample_value;
  logic out_valid, out_stall;
  logic signed [23:0] window_mean;
  logic [47:0] window_variance;
  logic [7:0] points_held;
  logic zero_span, dropped_full;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  window_board board;
  bit no_idle;      // both sides run back to back
  bit hold_req;     // ask the receiver for one long hold-off
  logic [31:0] last_time;
  int sent;
  int idle_cycles;

  time_window_mean_variance_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_time(sample_time), .sample_value(sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .window_mean(window_mean), .window_variance(window_variance),
    .points_held(points_held), .zero_span(zero_span), .dropped_full(dropped_full),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: draw a hold-off per result beat, then take the beat and check it.
  initial begin : receiver
    int gap;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        gap = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_result(window_mean, window_variance, points_held, zero_span, dropped_full);
    end
  end

  // Offer one sample beat after a random gap; keep valid high when the next gap is zero.
  task automatic send_sample(logic [31:0] t, logic [23:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_time <= t;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    board.note_sample(t, v);
    if (t > last_time) last_time = t;
    sent++;
  endtask

  task automatic reg_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] span, logic [47:0] floor_val);
    drain();
    reg_write(ADDR_SPAN, 64'(span));
    reg_write(ADDR_MINVAR, 64'(floor_val));
    board.span_reg = span;
    board.floor_reg = floor_val;
  endtask

  function automatic logic [23:0] pick_value(logic [23:0] level);
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom);
      default: return level + 24'($urandom_range(0, 512)) - 24'd256;
    endcase
  endfunction

  // Mostly forward steps with random content; a few backward timestamps as noise.
  task automatic run_phase(int n, int step_max);
    logic [31:0] t;
    logic [23:0] level;
    longint unsigned nxt;
    level = 24'($urandom);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) begin
        t = $urandom_range(0, last_time);
      end else begin
        nxt = longint'(last_time) + $urandom_range(0, step_max);
        t = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
      end
      if ($urandom_range(0, 31) == 0) level = 24'($urandom);
      send_sample(t, pick_value(level));
    end
  endtask

  initial begin : stimulus
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    sample_time = '0;
    sample_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    last_time = '0;
    sent = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: first sample, zero-length window, value extremes, time going
    // backward, a long jump, eviction by age under the reset window.
    send_sample(32'd0, 24'h7FFFFF);
    send_sample(32'd0, 24'h800000);
    send_sample(32'd10, 24'h800000);
    send_sample(32'd5, 24'h000000);
    send_sample(32'd20, 24'h7FFFFF);
    send_sample(32'd20, 24'h000001);
    send_sample(32'd1000000, 24'hFFFFFF);
    send_sample(32'd1000021, 24'h7FFFFF);
    send_sample(32'd2000100, 24'h800000);
    send_sample(32'd2000100, 24'h123456);
    send_sample(32'd3, 24'h7FFFFF);
    send_sample(32'd2500000, 24'h000000);

    // Zero-width window: every result is the newest value.
    set_window(32'd0, 48'd0);
    run_phase(60, 3);

    // Narrow window, long receiver hold-off so the block backs up.
    set_window(32'd200, 48'($urandom_range(0, 1000)));
    hold_req = 1'b1;
    run_phase(300, 40);

    // Floor at its top: variance is always the floor. No idling here.
    set_window(32'd1000, VAR_TOP);
    no_idle = 1'b1;
    run_phase(150, 100);
    no_idle = 1'b0;

    // Widest window: the ring fills and drops its oldest entry.
    set_window(32'hFFFF_FFFF, 48'd0);
    run_phase(160, 1000);

    set_window(32'd5000, {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47));
    run_phase(300, 2000);

    // Top of the time range: timestamps pile up at the maximum.
    set_window(32'($urandom_range(1, 100000)), 48'($urandom_range(0, 65535)));
    send_sample(32'hFFFF_0000, 24'h000000);
    run_phase(150, 2000);
    send_sample(32'hFFFF_FFFF, 24'h7FFFFF);
    send_sample(32'hFFFF_FFFF, 24'h800000);

    drain();
    repeat (1200) @(posedge clk);
    if (board.pending.size() != 0) board.mismatches++;
    $display("covered %0d samples, %0d results checked (%0d zero-span, %0d ring drops)",
             sent, board.checked, board.zero_seen, board.drop_seen);
    $display("%0d mismatches", board.mismatches);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/twmv_pkg.sv
rtl/twmv_ram.sv
rtl/twmv_div.sv
rtl/twmv_cfg.sv
rtl/time_window_mean_variance_top.sv
rtl/twmv_check.sv
test/tb_time_window_mean_variance_top.sv
